FILE: rtl/mls_pkg.sv
package mls_pkg;

  // Sieve range and prime list size
  localparam int MAX_LIMIT   = 65536;
  localparam int PRIME_SLOTS = 8192;

  // Field widths
  localparam int VAL_W  = 17;                        // integers, limit, query
  localparam int ADDR_W = $clog2(MAX_LIMIT + 1);     // store address
  localparam int PIDX_W = $clog2(PRIME_SLOTS);       // prime list address
  localparam int CNT_W  = $clog2(PRIME_SLOTS + 1);   // prime count
  localparam int PROD_W = 2 * VAL_W;                 // i * p
  localparam int MU_W   = 2;

  // Moebius codes, two's complement
  localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
  localparam logic signed [MU_W-1:0] MU_ONE  = 2'sb01;
  localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

  // One sieve store entry: composite mark, index of the smallest prime
  // factor in the prime list, and mu.
  typedef struct packed {
    logic                   comp;
    logic [PIDX_W-1:0]      lpi;
    logic signed [MU_W-1:0] mu;
  } sieve_entry_t;

  localparam int ENTRY_W = $bits(sieve_entry_t);

endpackage

FILE: rtl/mls_ram.sv
module mls_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mobius_linear_sieve.sv
// Moebius function by an incremental linear sieve, one result per query item.
// An out-of-range query is answered from idle; any other query first sieves
// each new integer up to it (read its entry, prime test, then product and mark
// per stored prime tried), then reads its own entry and returns mu. A new item
// waits until the last result is out. Results are one-cycle strobes; the
// receiver cannot stall. Reset and each limit write sweep the store, busy high.
module mobius_linear_sieve (
  input  logic                              clk,
  input  logic                              rst,
  // query item
  input  logic                              start,
  output logic                              busy,
  input  logic [mls_pkg::VAL_W-1:0]         query_index,
  // result item, one-cycle strobe
  output logic                              done,
  output logic signed [mls_pkg::MU_W-1:0]   mobius_value,
  output logic                              out_of_range,
  // limit register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mls_pkg::VAL_W-1:0]         upper_limit
);
  import mls_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,    // sweep the store: composite marks off, entry one mu = 1
    S_IDLE,
    S_RD_I,     // read entry of the next integer i
    S_CHK_I,    // prime test, append prime
    S_P_ISSUE,  // read prime 0
    S_P_MUL,    // product i*p, prefetch next prime
    S_P_MARK,   // mark i*p, decide whether the walk goes on
    S_Q_RD,     // read entry of the query
    S_Q_OUT     // return mu
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [VAL_W-1:0]   limit;
  logic [VAL_W-1:0]   next_int;    // integer under work / next to sieve
  logic [VAL_W-1:0]   qk;          // current query
  logic [CNT_W-1:0]   prime_total;
  logic [CNT_W-1:0]   idx;         // prime list walk position
  logic signed [MU_W-1:0] mu_i;
  logic [PIDX_W-1:0]  lpi_i;       // list index of smallest prime factor of i
  logic [PROD_W-1:0]  prod;
  logic               p_zero;

  // store ports
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  sieve_entry_t       st_wdata;
  logic               st_re;
  logic [ADDR_W-1:0]  st_raddr;
  sieve_entry_t       st_rdata;

  // prime list ports
  logic               pl_we;
  logic [PIDX_W-1:0]  pl_waddr;
  logic               pl_re;
  logic [PIDX_W-1:0]  pl_raddr;
  logic [VAL_W-1:0]   pl_rdata;

  logic               accept;
  logic               cfg_wr;
  logic               out_rng;
  logic               is_prime;
  logic               past_limit;
  logic               lp_hit;
  logic [CNT_W-1:0]   idx_inc;
  logic [VAL_W-1:0]   next_int_inc;
  logic [VAL_W-1:0]   cfg_sat;

  // a limit write wins over a query in the same cycle, so the query waits
  assign busy      = (state != S_IDLE) || cfg_wr;
  // limit writes only between queries or during a sweep
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign cfg_sat = (upper_limit > VAL_W'(MAX_LIMIT)) ? VAL_W'(MAX_LIMIT) : upper_limit;

  // query zero or above the limit needs no sieving
  assign out_rng = (query_index == '0) || (query_index > limit);

  assign is_prime     = !st_rdata.comp;
  assign past_limit   = (prod > PROD_W'(limit)) || p_zero;
  // p divides i exactly when p is the smallest prime factor of i
  assign lp_hit       = (idx[PIDX_W-1:0] == lpi_i);
  assign idx_inc      = idx + CNT_W'(1);
  assign next_int_inc = next_int + VAL_W'(1);

  // store and prime list control
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_addr;
    st_wdata = '{comp: 1'b0, lpi: '0, mu: MU_ZERO};
    st_re    = 1'b0;
    st_raddr = next_int[ADDR_W-1:0];
    pl_we    = 1'b0;
    pl_waddr = prime_total[PIDX_W-1:0];
    pl_re    = 1'b0;
    pl_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_wdata = '{comp: 1'b0, lpi: '0,
                     mu: (clr_addr == ADDR_W'(1)) ? MU_ONE : MU_ZERO};
      end
      S_RD_I: begin
        st_re = 1'b1;
      end
      S_CHK_I: begin
        if (is_prime) begin
          st_we    = 1'b1;
          st_waddr = next_int[ADDR_W-1:0];
          st_wdata = '{comp: 1'b0, lpi: prime_total[PIDX_W-1:0], mu: MU_NEG};
          pl_we    = (prime_total < CNT_W'(PRIME_SLOTS));
        end
      end
      S_P_ISSUE: begin
        pl_re = 1'b1;
      end
      S_P_MUL: begin
        pl_re    = (idx_inc < prime_total);
        pl_raddr = idx_inc[PIDX_W-1:0];
      end
      S_P_MARK: begin
        if (!past_limit) begin
          st_we    = 1'b1;
          st_waddr = prod[ADDR_W-1:0];
          st_wdata = '{comp: 1'b1, lpi: idx[PIDX_W-1:0],
                       mu: lp_hit ? MU_ZERO : -mu_i};
        end
      end
      S_Q_RD: begin
        st_re    = 1'b1;
        st_raddr = qk[ADDR_W-1:0];
      end
      S_IDLE, S_Q_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      limit       <= VAL_W'(MAX_LIMIT);
      next_int    <= VAL_W'(2);
      prime_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        // restart: new limit, empty prime list, fresh sweep
        limit       <= cfg_sat;
        next_int    <= VAL_W'(2);
        prime_total <= '0;
        clr_addr    <= '0;
        state       <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + ADDR_W'(1);
            if (clr_addr == ADDR_W'(MAX_LIMIT)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              qk <= query_index;
              if (out_rng) begin
                done         <= 1'b1;
                out_of_range <= 1'b1;
                mobius_value <= MU_ZERO;
              end else if (next_int <= query_index) begin
                state <= S_RD_I;
              end else begin
                state <= S_Q_RD;
              end
            end
          end
          S_RD_I: begin
            state <= S_CHK_I;
          end
          S_CHK_I: begin
            if (is_prime) begin
              mu_i  <= MU_NEG;
              lpi_i <= prime_total[PIDX_W-1:0];
              if (prime_total < CNT_W'(PRIME_SLOTS)) begin
                prime_total <= prime_total + CNT_W'(1);
              end
              state <= S_P_ISSUE;
            end else begin
              mu_i  <= st_rdata.mu;
              lpi_i <= st_rdata.lpi;
              // a composite i always has its factor in the list
              state <= (prime_total != '0) ? S_P_ISSUE : S_IDLE;
            end
            idx <= '0;
          end
          S_P_ISSUE: begin
            state <= S_P_MUL;
          end
          S_P_MUL: begin
            prod   <= PROD_W'(next_int) * PROD_W'(pl_rdata);
            p_zero <= (pl_rdata == '0);
            state  <= S_P_MARK;
          end
          S_P_MARK: begin
            if (!past_limit && !lp_hit && (idx_inc < prime_total)) begin
              idx   <= idx_inc;
              state <= S_P_MUL;
            end else begin
              // integer finished
              next_int <= next_int_inc;
              state    <= (next_int_inc <= qk) ? S_RD_I : S_Q_RD;
            end
          end
          S_Q_RD: begin
            state <= S_Q_OUT;
          end
          S_Q_OUT: begin
            done         <= 1'b1;
            out_of_range <= 1'b0;
            mobius_value <= st_rdata.mu;
            state        <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  mls_ram #(
    .DEPTH (MAX_LIMIT + 1),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mls_ram #(
    .DEPTH (PRIME_SLOTS),
    .WIDTH (VAL_W)
  ) u_primes (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (next_int),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

endmodule

FILE: tb/tb_mobius_linear_sieve.sv
module tb_mobius_linear_sieve;
  import mls_pkg::*;

  // Directed plan rows either carry a query item or a limit write.
  typedef enum bit {ROW_QUERY, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    logic signed [MU_W-1:0] mu;
    logic                   oor;
  } mobius_res_t;

  typedef struct {
    row_kind_t              kind;
    logic [VAL_W-1:0]       value;
    bit                     typed;   // expectation written in the row itself
    logic signed [MU_W-1:0] mu;
    logic                   oor;
  } plan_row_t;

  localparam int      RAND_PHASES    = 3;
  localparam int      ITEMS_PER_PH   = 420;
  localparam int      QUERY_CAP      = 3000;   // keeps random sieve growth cheap
  localparam int      SETTLE_CYCLES  = 8;
  localparam int      DRAIN_CYCLES   = 20;
  // One query at the full limit sieves ~65k integers, and every limit write
  // clears 65537 entries; this is several times the worst.
  localparam int      STALL_LIMIT    = 2_000_000;
  localparam int      REPORT_MAX     = 10;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [VAL_W-1:0]       query_index;
  logic                   done;
  logic signed [MU_W-1:0] mobius_value;
  logic                   out_of_range;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [VAL_W-1:0]       upper_limit;

  mobius_linear_sieve DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .query_index  (query_index),
    .done         (done),
    .mobius_value (mobius_value),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .upper_limit  (upper_limit)
  );

  // ---------------------------------------------------------------------
  // Sieve predictor: its own copy of the stores, prime list and limit.
  // ---------------------------------------------------------------------
  logic signed [MU_W-1:0] mu_tab    [0:MAX_LIMIT];
  bit                     composite [0:MAX_LIMIT];
  int unsigned            primes    [0:PRIME_SLOTS-1];
  int unsigned            prime_cnt;
  int unsigned            next_int;
  int unsigned            limit_now;

  mobius_res_t            pending_mu[$];   // expected results, oldest first
  plan_row_t              plan[$];

  int                     mismatches;
  int                     items_sent;
  int                     results_seen;
  int                     limit_writes;
  int                     stall_cnt;

  // Limit write: saturate, then restart the sieve from two.
  function automatic void restart_sieve_model(logic [VAL_W-1:0] value);
    limit_now = (value > MAX_LIMIT) ? MAX_LIMIT : value;
    foreach (composite[n]) composite[n] = 1'b0;
    prime_cnt = 0;
    next_int  = 2;
    mu_tab[1] = MU_ONE;
  endfunction

  // Extends the linear sieve through k and returns mu(k), or the
  // out-of-range flag for zero or anything above the current limit.
  function automatic mobius_res_t mobius_of(logic [VAL_W-1:0] k);
    mobius_res_t      res;
    int unsigned      i;
    int unsigned      p;
    longint unsigned  j;
    if (k == 0 || k > limit_now) begin
      res.mu  = MU_ZERO;
      res.oor = 1'b1;
      return res;
    end
    while (next_int <= k) begin
      i = next_int;
      if (!composite[i]) begin
        // a full prime list still gets mu, just not the slot
        if (prime_cnt < PRIME_SLOTS) begin
          primes[prime_cnt] = i;
          prime_cnt++;
        end
        mu_tab[i] = MU_NEG;
      end
      for (int idx = 0; idx < prime_cnt; idx++) begin
        p = primes[idx];
        j = longint'(i) * longint'(p);
        if (j > limit_now || p == 0) break;
        composite[j] = 1'b1;
        if (i % p == 0) begin
          mu_tab[j] = MU_ZERO;   // square factor, walk stops here
          break;
        end
        mu_tab[j] = -mu_tab[i];
      end
      next_int++;
    end
    res.mu  = mu_tab[k];
    res.oor = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are judged on the
  // rising edge from the values that held just before it.
  // ---------------------------------------------------------------------
  task automatic send_query(input logic [VAL_W-1:0] k, input bit typed,
                            input logic signed [MU_W-1:0] t_mu, input logic t_oor);
    mobius_res_t res;
    @(negedge clk);
    start       = 1'b1;
    query_index = k;
    do @(posedge clk); while (busy);
    // item taken at this edge: advance the predictor
    res = mobius_of(k);
    if (typed) begin
      res.mu  = t_mu;
      res.oor = t_oor;
    end
    pending_mu.insert(pending_mu.size(), res);
    items_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    start       = 1'b0;
    query_index = VAL_W'($urandom);   // noise while start is low
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_mu.size() != 0) @(posedge clk);
  endtask

  // Limit writes only happen once the block has nothing in flight.
  task automatic write_limit(input logic [VAL_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    start       = 1'b0;
    cfg_valid   = 1'b1;
    upper_limit = value;
    do @(posedge clk); while (!cfg_ready);
    restart_sieve_model(value);
    limit_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [VAL_W-1:0] value,
                         input bit typed, input logic signed [MU_W-1:0] mu,
                         input logic oor);
    plan_row_t row;
    row = '{kind, value, typed, mu, oor};
    plan.insert(plan.size(), row);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every strobe must match the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mobius_res_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_mu.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("[%0t] unexpected result: mu=%0d oor=%0b", $realtime,
                   mobius_value, out_of_range);
        mismatches++;
      end else begin
        want = pending_mu.pop_front();
        if (mobius_value !== want.mu || out_of_range !== want.oor) begin
          if (mismatches < REPORT_MAX)
            $display("[%0t] mismatch: expected mu=%0d oor=%0b, got mu=%0d oor=%0b",
                     $realtime, want.mu, want.oor, mobius_value, out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [VAL_W-1:0] lim_value;
    logic [VAL_W-1:0] k;
    int unsigned      eff;
    int unsigned      cap;
    int               pick;
    bit               quiet;

    rst          = 1'b1;
    start        = 1'b0;
    query_index  = '0;
    cfg_valid    = 1'b0;
    upper_limit  = '0;
    items_sent   = 0;
    limit_writes = 0;
    foreach (mu_tab[n]) mu_tab[n] = MU_ZERO;
    foreach (primes[n]) primes[n] = 0;
    restart_sieve_model(VAL_W'(MAX_LIMIT));

    // Directed plan. Default limit is the maximum after reset.
    add_row(ROW_QUERY, 1,           1, MU_ONE,  1'b0);  // seeded entry
    add_row(ROW_QUERY, 0,           1, MU_ZERO, 1'b1);  // query zero
    add_row(ROW_QUERY, 2,           0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 4,           0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 6,           0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 30,          0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 3,           0, MU_ZERO, 1'b0);  // already sieved
    add_row(ROW_QUERY, 17'h1FFFF,   1, MU_ZERO, 1'b1);  // all ones, above limit
    add_row(ROW_QUERY, VAL_W'(MAX_LIMIT+1), 1, MU_ZERO, 1'b1);  // just past the limit
    add_row(ROW_QUERY, VAL_W'(MAX_LIMIT),   1, MU_ZERO, 1'b0);  // 2^16, full sieve
    add_row(ROW_QUERY, VAL_W'(MAX_LIMIT-1), 0, MU_ZERO, 1'b0);  // 3*5*17*257
    add_row(ROW_QUERY, 65521,       0, MU_ZERO, 1'b0);  // largest prime in range
    add_row(ROW_LIMIT, 0,           0, MU_ZERO, 1'b0);  // limit zero
    add_row(ROW_QUERY, 1,           1, MU_ZERO, 1'b1);
    add_row(ROW_QUERY, 0,           1, MU_ZERO, 1'b1);
    add_row(ROW_LIMIT, 1,           0, MU_ZERO, 1'b0);  // smallest useful limit
    add_row(ROW_QUERY, 1,           1, MU_ONE,  1'b0);
    add_row(ROW_QUERY, 2,           1, MU_ZERO, 1'b1);
    add_row(ROW_LIMIT, 12,          0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 12,          0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 13,          1, MU_ZERO, 1'b1);
    add_row(ROW_QUERY, 11,          0, MU_ZERO, 1'b0);
    add_row(ROW_QUERY, 7,           0, MU_ZERO, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // the clearing pass after reset shows up as busy; the first send waits

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMIT)
        write_limit(plan[r].value);
      else
        send_query(plan[r].value, plan[r].typed, plan[r].mu, plan[r].oor);
    end

    // Random phases: moderate limit, saturating all-ones write, tiny limit.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       lim_value = VAL_W'($urandom_range(QUERY_CAP, 200));
        1:       lim_value = 17'h1FFFF;
        default: lim_value = VAL_W'($urandom_range(100, 2));
      endcase
      write_limit(lim_value);
      eff = limit_now;
      cap = (eff < QUERY_CAP) ? eff : QUERY_CAP;

      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        // sender holds off until the block is empty, then resumes
        if (ph == 1 && n == ITEMS_PER_PH / 2) begin
          @(negedge clk);
          start = 1'b0;
          drain_results();
        end
        quiet = (ph == 0 && n >= 100 && n < 320);
        if (!quiet && $urandom_range(99, 0) < 8)
          idle_sender($urandom_range(6, 1));

        pick = $urandom_range(99, 0);
        if (pick < 80)
          k = VAL_W'($urandom_range(cap, 1));
        else if (pick < 88)
          k = VAL_W'($urandom_range(17'h1FFFF, eff + 1));
        else if (pick < 93)
          k = '0;
        else
          k = VAL_W'(cap);   // top of the queried range, the limit itself when small
        send_query(k, 0, MU_ZERO, 1'b0);
      end
    end

    @(negedge clk);
    start = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d query items and %0d results over %0d limit settings",
             items_sent, results_seen, limit_writes + 1);
    $display("sieve reached %0d with %0d primes stored; %0d mismatches",
             next_int - 1, prime_cnt, mismatches);
    if (mismatches == 0 && pending_mu.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mls_pkg.sv
rtl/mls_ram.sv
rtl/mobius_linear_sieve.sv
tb/tb_mobius_linear_sieve.sv
